// ----- rtl/bitmap_fixed_block_allocator_defines.svh -----
// Assertion macros for the bitmap block allocator.
// Included by files that carry concurrent assertions; no other dependencies.
`ifndef BITMAP_FIXED_BLOCK_ALLOCATOR_DEFINES_SVH
`define BITMAP_FIXED_BLOCK_ALLOCATOR_DEFINES_SVH
`ifndef SYNTHESIS
`define BFBA_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);
`define BFBA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define BFBA_ASSERT(lbl, clk, rstn, prop, msg)
`define BFBA_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ----- rtl/bfba_pkg.sv -----
// Shared types and constants for the bitmap block allocator.
// No dependencies.
package bfba_pkg;

  localparam int unsigned SIZE_W      = 17;
  localparam int unsigned OFFSET_W    = 27;
  localparam int unsigned INDEX_W     = 11;
  localparam int unsigned COUNT_W     = 12;
  localparam int unsigned BYTES_W     = 17;
  localparam int unsigned CFG_DATA_W  = 17;
  localparam int unsigned COUNT_LIMIT = 4096;

  typedef enum logic [1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_BAD_SIZE = 2'd2,
    STATUS_OUTSIDE  = 2'd3
  } status_e;

  typedef enum logic [0:0] {
    CFG_BLOCK_COUNT = 1'b0,
    CFG_BLOCK_BYTES = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    kind_e                kind;
    logic [SIZE_W-1:0]    request_size;
    logic [OFFSET_W-1:0]  byte_offset;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [OFFSET_W-1:0]  result_offset;
    logic [INDEX_W-1:0]   block_index;
  } rsp_t;

endpackage

// ----- rtl/bfba_stream_if.sv -----
// Valid/ready stream channel carrying one word of payload type T.
// Used with bfba_pkg::req_t and bfba_pkg::rsp_t.
interface bfba_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/bfba_div.sv -----
// Radix-2 restoring divider, one quotient bit per cycle.
// Standalone; caller guarantees the quotient fits in QUOT_W bits.
module bfba_div #(
  parameter int unsigned DIVIDEND_W = 27,
  parameter int unsigned DIVISOR_W  = 23,
  parameter int unsigned QUOT_W     = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic [QUOT_W-1:0]     quot_o,
  output logic [DIVIDEND_W-1:0] rem_o,
  output logic                  done_o
);

  localparam int unsigned DSH_W = DIVISOR_W + QUOT_W - 1;
  localparam int unsigned CMP_W = (DSH_W > DIVIDEND_W) ? DSH_W : DIVIDEND_W;
  localparam int unsigned CNT_W = (QUOT_W > 1) ? $clog2(QUOT_W) : 1;

  logic [DIVIDEND_W-1:0] rem_q, rem_d;
  logic [DSH_W-1:0]      dsh_q, dsh_d;
  logic [QUOT_W-1:0]     quot_q, quot_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  done_q, done_d;
  logic                  ge;
  logic [CMP_W-1:0]      diff;

  assign ge   = CMP_W'(rem_q) >= CMP_W'(dsh_q);
  assign diff = CMP_W'(rem_q) - CMP_W'(dsh_q);

  always_comb begin
    rem_d  = rem_q;
    dsh_d  = dsh_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = dividend_i;
      dsh_d  = DSH_W'(divisor_i) << (QUOT_W - 1);
      quot_d = '0;
      cnt_d  = CNT_W'(QUOT_W - 1);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (ge) begin
        rem_d = DIVIDEND_W'(diff);
      end
      quot_d = (quot_q << 1) | QUOT_W'(ge);
      dsh_d  = dsh_q >> 1;
      if (cnt_q == '0) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end else begin
        cnt_d = cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q  <= '0;
      dsh_q  <= '0;
      quot_q <= '0;
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      rem_q  <= rem_d;
      dsh_q  <= dsh_d;
      quot_q <= quot_d;
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  assign quot_o = quot_q;
  assign rem_o  = rem_q;
  assign done_o = done_q;

endmodule

// ----- rtl/bitmap_fixed_block_allocator.sv -----
// Fixed-size block allocator: one request word in, one response word out. The occupancy
// bitmap sits in a single MAX_WORDS x WORD_BITS memory with one read and one write port.
// An allocate reads one bitmap word per cycle from the last word that granted until a
// word with a free bit shows up (its lowest free bit is then set) or all words are read.
// A free goes through one shared radix-2 divider twice (word, then bit within the word),
// each pass giving a QW-bit quotient with QW the wider of the word and bit index widths,
// then a read-modify-write of the bitmap word.
// After reset, after any configuration write and for a clear request, the bitmap is zeroed
// by a pass over all MAX_WORDS words (one word a cycle) during which no request is taken;
// configuration writes are still taken and restart the pass. Requests are accepted while an
// earlier response still waits in the output register.
`include "bitmap_fixed_block_allocator_defines.svh"
module bitmap_fixed_block_allocator #(
  parameter int unsigned WORD_BITS = 32,
  parameter int unsigned MAX_WORDS = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  bfba_pkg::cfg_idx_e               cfg_idx_i,
  input  logic [bfba_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  bfba_stream_if.sink                      req,
  bfba_stream_if.source                    rsp
);

  localparam int unsigned BIT_W    = $clog2(WORD_BITS);
  localparam int unsigned WIDX_W   = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
  localparam int unsigned WCNT_W   = $clog2(MAX_WORDS + 1);
  localparam int unsigned BLK_W    = $clog2(bfba_pkg::COUNT_LIMIT + WORD_BITS);
  localparam int unsigned BYTE_W   = BLK_W + bfba_pkg::BYTES_W;
  localparam int unsigned STEP_W   = $clog2(WORD_BITS + 1) + bfba_pkg::BYTES_W;
  localparam int unsigned QW       = (WIDX_W > BIT_W) ? WIDX_W : BIT_W;
  localparam int unsigned OFFCMP_W = (BYTE_W > bfba_pkg::OFFSET_W) ? BYTE_W
                                                                    : bfba_pkg::OFFSET_W;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV_WORD,
    ST_DIV_BIT,
    ST_FREE_WR,
    ST_POST
  } state_e;

  // configuration and pool geometry
  logic [bfba_pkg::COUNT_W-1:0] bc_q, bc_d;
  logic [bfba_pkg::BYTES_W-1:0] bb_q, bb_d;
  logic [WCNT_W-1:0]            words_q, words_d;
  logic [BYTE_W-1:0]            pool_bytes_q, pool_bytes_d;
  logic [BLK_W-1:0]             acc_blk_q, acc_blk_d;
  logic [BYTE_W-1:0]            acc_byte_q, acc_byte_d;
  logic [WIDX_W-1:0]            clr_cnt_q, clr_cnt_d;
  logic                         post_pend_q, post_pend_d;
  logic [WIDX_W-1:0]            start_q, start_d;

  // control and working registers
  state_e                       state_q, state_d;
  logic [WIDX_W-1:0]            scan_next_q, scan_next_d;
  logic [WCNT_W-1:0]            scan_cnt_q, scan_cnt_d;
  logic                         rd_valid_q, rd_valid_d;
  logic [WIDX_W-1:0]            rd_word_q, rd_word_d;
  logic [BLK_W-1:0]             idx_q, idx_d;
  logic [WIDX_W-1:0]            word_q, word_d;
  logic [BIT_W-1:0]             bit_q, bit_d;
  bfba_pkg::rsp_t               res_q, res_d;
  bfba_pkg::rsp_t               out_q, out_d;
  logic                         out_valid_q, out_valid_d;

  // bitmap memory
  logic [WORD_BITS-1:0]         occ_mem [MAX_WORDS];
  logic                         mem_we;
  logic [WIDX_W-1:0]            mem_waddr;
  logic [WORD_BITS-1:0]         mem_wdata;
  logic                         mem_re;
  logic [WIDX_W-1:0]            mem_raddr;
  logic [WORD_BITS-1:0]         mem_rdata_q;

  // divider
  logic                         div_start;
  logic [bfba_pkg::OFFSET_W-1:0] div_dividend;
  logic [STEP_W-1:0]            div_divisor;
  logic [QW-1:0]                div_quot;
  logic [bfba_pkg::OFFSET_W-1:0] div_rem;
  logic                         div_done;

  // datapath helpers
  logic                         req_fire;
  logic                         word_full;
  logic [BIT_W-1:0]             fz_bit;
  logic [BLK_W-1:0]             alloc_idx;
  logic [BLK_W-1:0]             free_idx;
  logic [BYTE_W-1:0]            mul_prod;
  logic [STEP_W-1:0]            step_bytes;
  logic [WCNT_W-1:0]            scan_inc;
  logic                         start_ok;

  assign req_fire   = req.valid && req.ready;
  assign req.ready  = (state_q == ST_IDLE);
  assign rsp.valid  = out_valid_q;
  assign rsp.data   = out_q;

  assign word_full  = (mem_rdata_q == {WORD_BITS{1'b1}});
  assign alloc_idx  = BLK_W'(rd_word_q) * BLK_W'(WORD_BITS) + BLK_W'(fz_bit);
  assign free_idx   = BLK_W'(word_q) * BLK_W'(WORD_BITS) + BLK_W'(bit_q);
  assign mul_prod   = BYTE_W'(idx_q) * BYTE_W'(bb_q);
  assign step_bytes = STEP_W'(bb_q) * STEP_W'(WORD_BITS);
  assign scan_inc   = WCNT_W'(scan_next_q) + WCNT_W'(1);
  assign start_ok   = WCNT_W'(start_q) < words_q;

  // lowest clear bit of the word just read
  always_comb begin
    fz_bit = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (!mem_rdata_q[i]) begin
        fz_bit = BIT_W'(i);
      end
    end
  end

  bfba_div #(
    .DIVIDEND_W (bfba_pkg::OFFSET_W),
    .DIVISOR_W  (STEP_W),
    .QUOT_W     (QW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .rem_o      (div_rem),
    .done_o     (div_done)
  );

  always_comb begin
    state_d      = state_q;
    bc_d         = bc_q;
    bb_d         = bb_q;
    words_d      = words_q;
    pool_bytes_d = pool_bytes_q;
    acc_blk_d    = acc_blk_q;
    acc_byte_d   = acc_byte_q;
    clr_cnt_d    = clr_cnt_q;
    post_pend_d  = post_pend_q;
    start_d      = start_q;
    scan_next_d  = scan_next_q;
    scan_cnt_d   = scan_cnt_q;
    rd_valid_d   = 1'b0;
    rd_word_d    = rd_word_q;
    idx_d        = idx_q;
    word_d       = word_q;
    bit_d        = bit_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && !rsp.ready;
    mem_we       = 1'b0;
    mem_waddr    = '0;
    mem_wdata    = '0;
    mem_re       = 1'b0;
    mem_raddr    = '0;
    div_start    = 1'b0;
    div_dividend = req.data.byte_offset;
    div_divisor  = step_bytes;

    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        // pool word count and byte size are rebuilt alongside the sweep
        if (acc_blk_q < BLK_W'(bc_q)) begin
          words_d      = WCNT_W'(clr_cnt_q) + WCNT_W'(1);
          pool_bytes_d = acc_byte_q + BYTE_W'(step_bytes);
          acc_blk_d    = acc_blk_q + BLK_W'(WORD_BITS);
          acc_byte_d   = acc_byte_q + BYTE_W'(step_bytes);
        end
        if (clr_cnt_q == WIDX_W'(MAX_WORDS - 1)) begin
          state_d = post_pend_q ? ST_POST : ST_IDLE;
        end else begin
          clr_cnt_d = clr_cnt_q + WIDX_W'(1);
        end
      end

      ST_IDLE: begin
        if (req_fire) begin
          res_d = '0;
          unique case (req.data.kind)
            bfba_pkg::KIND_ALLOC: begin
              if (req.data.request_size == '0 || req.data.request_size > bb_q) begin
                res_d.status = bfba_pkg::STATUS_BAD_SIZE;
                state_d      = ST_POST;
              end else if (words_q == '0) begin
                res_d.status = bfba_pkg::STATUS_FULL;
                state_d      = ST_POST;
              end else begin
                scan_next_d = start_ok ? start_q : '0;
                scan_cnt_d  = '0;
                state_d     = ST_SCAN;
              end
            end
            bfba_pkg::KIND_FREE: begin
              if (OFFCMP_W'(req.data.byte_offset) >= OFFCMP_W'(pool_bytes_q)) begin
                res_d.status = bfba_pkg::STATUS_OUTSIDE;
                state_d      = ST_POST;
              end else begin
                div_start = 1'b1;
                state_d   = ST_DIV_WORD;
              end
            end
            bfba_pkg::KIND_CLEAR: begin
              res_d.status = bfba_pkg::STATUS_OK;
              post_pend_d  = 1'b1;
              clr_cnt_d    = '0;
              words_d      = '0;
              pool_bytes_d = '0;
              acc_blk_d    = '0;
              acc_byte_d   = '0;
              state_d      = ST_CLEAR;
            end
            default: begin
              res_d.status = bfba_pkg::STATUS_OK;
              state_d      = ST_POST;
            end
          endcase
        end
      end

      // one read issued per cycle, data checked the cycle after
      ST_SCAN: begin
        if (rd_valid_q && !word_full) begin
          mem_we    = 1'b1;
          mem_waddr = rd_word_q;
          mem_wdata = mem_rdata_q | (WORD_BITS'(1) << fz_bit);
          start_d   = rd_word_q;
          idx_d     = alloc_idx;
          state_d   = ST_MUL;
        end else if (scan_cnt_q < words_q) begin
          mem_re      = 1'b1;
          mem_raddr   = scan_next_q;
          rd_word_d   = scan_next_q;
          rd_valid_d  = 1'b1;
          scan_cnt_d  = scan_cnt_q + WCNT_W'(1);
          scan_next_d = (scan_inc >= words_q) ? '0 : WIDX_W'(scan_inc);
        end else begin
          res_d        = '0;
          res_d.status = bfba_pkg::STATUS_FULL;
          state_d      = ST_POST;
        end
      end

      ST_MUL: begin
        res_d               = '0;
        res_d.status        = bfba_pkg::STATUS_OK;
        res_d.result_offset = mul_prod[bfba_pkg::OFFSET_W-1:0];
        res_d.block_index   = idx_q[bfba_pkg::INDEX_W-1:0];
        state_d             = ST_POST;
      end

      ST_DIV_WORD: begin
        if (div_done) begin
          word_d       = WIDX_W'(div_quot);
          div_start    = 1'b1;
          div_dividend = div_rem;
          div_divisor  = STEP_W'(bb_q);
          state_d      = ST_DIV_BIT;
        end
      end

      ST_DIV_BIT: begin
        if (div_done) begin
          bit_d     = BIT_W'(div_quot);
          mem_re    = 1'b1;
          mem_raddr = word_q;
          state_d   = ST_FREE_WR;
        end
      end

      ST_FREE_WR: begin
        mem_we            = 1'b1;
        mem_waddr         = word_q;
        mem_wdata         = mem_rdata_q & ~(WORD_BITS'(1) << bit_q);
        res_d             = '0;
        res_d.status      = bfba_pkg::STATUS_OK;
        res_d.block_index = free_idx[bfba_pkg::INDEX_W-1:0];
        state_d           = ST_POST;
      end

      ST_POST: begin
        if (!out_valid_q || rsp.ready) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          post_pend_d = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // a register write re-initializes the pool
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bfba_pkg::CFG_BLOCK_COUNT: bc_d = cfg_data_i[bfba_pkg::COUNT_W-1:0];
        bfba_pkg::CFG_BLOCK_BYTES: bb_d = cfg_data_i[bfba_pkg::BYTES_W-1:0];
        default: ;
      endcase
      start_d      = '0;
      post_pend_d  = 1'b0;
      clr_cnt_d    = '0;
      words_d      = '0;
      pool_bytes_d = '0;
      acc_blk_d    = '0;
      acc_byte_d   = '0;
      state_d      = ST_CLEAR;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      bc_q         <= bfba_pkg::COUNT_W'(2048);
      bb_q         <= bfba_pkg::BYTES_W'(64);
      words_q      <= '0;
      pool_bytes_q <= '0;
      acc_blk_q    <= '0;
      acc_byte_q   <= '0;
      clr_cnt_q    <= '0;
      post_pend_q  <= 1'b0;
      start_q      <= '0;
      scan_next_q  <= '0;
      scan_cnt_q   <= '0;
      rd_valid_q   <= 1'b0;
      rd_word_q    <= '0;
      idx_q        <= '0;
      word_q       <= '0;
      bit_q        <= '0;
      res_q        <= '0;
      out_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      bc_q         <= bc_d;
      bb_q         <= bb_d;
      words_q      <= words_d;
      pool_bytes_q <= pool_bytes_d;
      acc_blk_q    <= acc_blk_d;
      acc_byte_q   <= acc_byte_d;
      clr_cnt_q    <= clr_cnt_d;
      post_pend_q  <= post_pend_d;
      start_q      <= start_d;
      scan_next_q  <= scan_next_d;
      scan_cnt_q   <= scan_cnt_d;
      rd_valid_q   <= rd_valid_d;
      rd_word_q    <= rd_word_d;
      idx_q        <= idx_d;
      word_q       <= word_d;
      bit_q        <= bit_d;
      res_q        <= res_d;
      out_q        <= out_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      occ_mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      mem_rdata_q <= occ_mem[mem_raddr];
    end
  end

  `BFBA_ASSERT_ALWAYS(a_alloc_sets_one_bit, clk_i, (mem_we && state_q == ST_SCAN) |-> ($countones(mem_wdata) == $countones(mem_rdata_q) + 1), "allocate must set exactly one new bitmap bit")
  `BFBA_ASSERT(a_free_clears_one_bit, clk_i, rst_ni, (state_q == ST_FREE_WR) |-> ($countones(mem_rdata_q & ~mem_wdata) <= 1 && (mem_wdata & ~mem_rdata_q) == '0), "free may only clear a single bit")
  `BFBA_ASSERT(a_free_word_in_pool, clk_i, rst_ni, (div_done && state_q == ST_DIV_WORD) |-> (div_quot < words_q), "freed word index beyond pool")
  `BFBA_ASSERT(a_one_item_at_a_time, clk_i, rst_ni, (req.valid && req.ready) |=> !req.ready, "request accepted while busy")

endmodule
